>>> sv/bsfe_pkg.sv
package bsfe_pkg;

   typedef enum logic [1:0] {
      CMD_BSF   = 2'd0,
      CMD_BSR   = 2'd1,
      CMD_BEXTR = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      SIZE_16 = 2'd0,
      SIZE_32 = 2'd1,
      SIZE_64 = 2'd2
   } size_type;

   localparam int unsigned DATA_W  = 64;
   localparam int unsigned INDEX_W = 6;
   localparam int unsigned WIDTH_W = 7;

   localparam logic [DATA_W-1:0] MASK_16 = 64'h0000_0000_0000_FFFF;
   localparam logic [DATA_W-1:0] MASK_32 = 64'h0000_0000_FFFF_FFFF;
   localparam logic [DATA_W-1:0] MASK_64 = 64'hFFFF_FFFF_FFFF_FFFF;

   // after decode: masked operand, extract window
   typedef struct packed {
      logic                cmd_ok;
      cmd_type             cmd;
      logic [DATA_W-1:0]   operand;
      logic [DATA_W-1:0]   scan_vec;
      logic                scan_zero;
      logic [DATA_W-1:0]   second;
      logic [INDEX_W-1:0]  start;
      logic [WIDTH_W-1:0]  width;
      logic                ext_zero;
   } s1_type;

   // after bit search and field shift
   typedef struct packed {
      logic                cmd_ok;
      cmd_type             cmd;
      logic                scan_zero;
      logic [DATA_W-1:0]   second;
      logic [INDEX_W-1:0]  idx;
      logic [DATA_W-1:0]   field;
   } s2_type;

   // final result
   typedef struct packed {
      logic                cmd_ok;
      cmd_type             cmd;
      logic [DATA_W-1:0]   result;
      logic                zero_flag;
      logic                parity_flag;
   } s3_type;

endpackage

>>> sv/bsfe_req_if.sv
interface bsfe_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [63:0] operand;
   logic [63:0] second_operand;
   logic [1:0]  size_sel;

   modport source (output valid, cmd, operand, second_operand, size_sel, input ready);
   modport sink   (input valid, cmd, operand, second_operand, size_sel, output ready);
endinterface

>>> sv/bsfe_rsp_if.sv
interface bsfe_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result;
   logic        zero_flag;
   logic        parity_flag;

   modport source (output valid, result, zero_flag, parity_flag, input ready);
   modport sink   (input valid, result, zero_flag, parity_flag, output ready);
endinterface

>>> sv/bsfe_scan.sv
module bsfe_scan (
   input  logic [bsfe_pkg::DATA_W-1:0]  vec,
   output logic [bsfe_pkg::INDEX_W-1:0] idx
);
   import bsfe_pkg::*;

   localparam int unsigned GROUPS = 8;
   localparam int unsigned GBITS  = DATA_W / GROUPS;

   logic [GROUPS-1:0] group_any;
   logic [2:0]        group_low [GROUPS];
   logic [2:0]        group_sel;

   // lowest set bit inside each byte
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         group_any[g] = |vec[g*GBITS +: GBITS];
         group_low[g] = 3'd0;
         for (int b = GBITS - 1; b >= 0; b--) begin
            if (vec[g*GBITS + b]) begin
               group_low[g] = 3'(b);
            end
         end
      end
   end

   // lowest byte that holds a set bit
   always_comb begin
      group_sel = 3'd0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (group_any[g]) begin
            group_sel = 3'(g);
         end
      end
   end

   assign idx = {group_sel, group_low[group_sel]};

endmodule

>>> sv/bit_scan_and_field_extract_unit.sv
// bit scan forward / reverse and bit field extract
// a request passes through the registered stages decode, search and shift, result select in turn
// throughput: one request per cycle, sustained, as long as rsp is taken
// a stalled result holds the whole pipeline in place; nothing is dropped
// reset (synchronous, active high) clears the three stage valid bits only
module bit_scan_and_field_extract_unit (
   input  logic       clock,
   input  logic       reset,
   bsfe_req_if.sink   req_ch,
   bsfe_rsp_if.source rsp_ch
);
   import bsfe_pkg::*;

   // stage valid bits and payload registers
   logic   s1_valid_ff, s2_valid_ff, s3_valid_ff;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;

   // a stage may load when it is empty or its content moves on
   logic s1_ready, s2_ready, s3_ready;

   assign s3_ready     = !s3_valid_ff || rsp_ch.ready;
   assign s2_ready     = !s2_valid_ff || s3_ready;
   assign s1_ready     = !s1_valid_ff || s2_ready;
   assign req_ch.ready = s1_ready;

   // ---------------- stage 1: decode ----------------
   // operand size mask, zero test of masked operand, extract window
   logic [DATA_W-1:0]  masked;
   logic [7:0]         size_bits;
   logic [7:0]         ext_start;
   logic [7:0]         ext_len;
   logic [WIDTH_W-1:0] room;
   logic               start_oob;

   always_comb begin
      case (size_type'(req_ch.size_sel))
         SIZE_16: begin
            masked    = req_ch.operand & MASK_16;
            size_bits = 8'd16;
         end
         SIZE_32: begin
            masked    = req_ch.operand & MASK_32;
            size_bits = 8'd32;
         end
         default: begin
            // 64 bits, also the unused selector code
            masked    = req_ch.operand & MASK_64;
            size_bits = 8'd64;
         end
      endcase

      ext_start = req_ch.second_operand[7:0];
      ext_len   = req_ch.second_operand[15:8];
      start_oob = ext_start >= size_bits;
      // only meaningful when start is in range, then 1..64
      room      = WIDTH_W'(size_bits - ext_start);

      s1_in.cmd       = cmd_type'(req_ch.cmd);
      s1_in.cmd_ok    = 1'b1;
      case (cmd_type'(req_ch.cmd))
         CMD_BSF, CMD_BSR, CMD_BEXTR: s1_in.cmd_ok = 1'b1;
         default:                     s1_in.cmd_ok = 1'b0;
      endcase
      s1_in.operand   = req_ch.operand;
      s1_in.scan_zero = (masked == '0);
      // reverse scan becomes a forward scan on the mirrored word
      for (int i = 0; i < DATA_W; i++) begin
         s1_in.scan_vec[i] = (cmd_type'(req_ch.cmd) == CMD_BSR) ?
                             masked[DATA_W-1-i] : masked[i];
      end
      s1_in.second    = req_ch.second_operand;
      s1_in.start     = ext_start[INDEX_W-1:0];
      s1_in.width     = (ext_len < {1'b0, room}) ? ext_len[WIDTH_W-1:0] : room;
      s1_in.ext_zero  = start_oob || (ext_len == 8'd0);
   end

   // ---------------- stage 2: search and shift ----------------
   logic [INDEX_W-1:0] tz_idx;
   logic [DATA_W-1:0]  field_mask;

   bsfe_scan u_scan (
      .vec (s1_ff.scan_vec),
      .idx (tz_idx)
   );

   always_comb begin
      // shift by the full width yields zero, so width 64 gives all ones
      field_mask      = ~(MASK_64 << s1_ff.width);
      s2_in.cmd_ok    = s1_ff.cmd_ok;
      s2_in.cmd       = s1_ff.cmd;
      s2_in.scan_zero = s1_ff.scan_zero;
      s2_in.second    = s1_ff.second;
      // mirrored search: highest index is 63 minus the count
      s2_in.idx       = (s1_ff.cmd == CMD_BSR) ? ~tz_idx : tz_idx;
      s2_in.field     = s1_ff.ext_zero ? '0 :
                        ((s1_ff.operand >> s1_ff.start) & field_mask);
   end

   // ---------------- stage 3: result select and flags ----------------
   always_comb begin
      s3_in.cmd_ok      = s2_ff.cmd_ok;
      s3_in.cmd         = s2_ff.cmd;
      s3_in.result      = '0;
      s3_in.zero_flag   = 1'b0;
      s3_in.parity_flag = 1'b0;
      if (s2_ff.cmd_ok) begin
         case (s2_ff.cmd)
            CMD_BSF, CMD_BSR: begin
               if (s2_ff.scan_zero) begin
                  // zero source: second operand passes through
                  s3_in.result      = s2_ff.second;
                  s3_in.zero_flag   = 1'b1;
                  s3_in.parity_flag = 1'b1;
               end else begin
                  s3_in.result      = {{(DATA_W-INDEX_W){1'b0}}, s2_ff.idx};
                  s3_in.parity_flag = ~^s2_ff.idx;
               end
            end
            CMD_BEXTR: begin
               s3_in.result    = s2_ff.field;
               s3_in.zero_flag = (s2_ff.field == '0);
            end
            default: begin
               s3_in.result = '0;
            end
         endcase
      end
   end

   // ---------------- pipeline registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_ch.valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) s1_ff <= s1_in;
      if (s2_ready) s2_ff <= s2_in;
      if (s3_ready) s3_ff <= s3_in;
   end

   // output register drives the response channel
   assign rsp_ch.valid       = s3_valid_ff;
   assign rsp_ch.result      = s3_ff.result;
   assign rsp_ch.zero_flag   = s3_ff.zero_flag;
   assign rsp_ch.parity_flag = s3_ff.parity_flag;

   // ---------------- assertions ----------------
   // a nonzero scan returns an index below 64
   a_scan_index: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_ff.cmd_ok && (s3_ff.cmd == CMD_BSF || s3_ff.cmd == CMD_BSR)
       && !s3_ff.zero_flag) |-> (s3_ff.result[DATA_W-1:INDEX_W] == '0))
      else $error("scan index out of range");

   // extract never sets parity
   a_extract_pf: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_ff.cmd_ok && s3_ff.cmd == CMD_BEXTR) |-> !s3_ff.parity_flag)
      else $error("extract produced parity flag");

   // a zero scan always reports parity even
   a_scan_zero_pf: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_ff.cmd_ok && (s3_ff.cmd == CMD_BSF || s3_ff.cmd == CMD_BSR)
       && s3_ff.zero_flag) |-> s3_ff.parity_flag)
      else $error("zero scan without parity flag");

   // middle stage holds while the output is stalled
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s3_valid_ff && !rsp_ch.ready) |=> (s2_valid_ff && $stable(s2_ff)))
      else $error("stage 2 lost data during stall");

endmodule

>>> tb/sv/bsfe_outcome_checker.sv
module bsfe_outcome_checker (
   input  logic clock,
   input  logic reset,
   bsfe_req_if  req_mon,
   bsfe_rsp_if  rsp_mon,
   output int   fault_count,
   output int   outstanding
);
   import bsfe_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] result;
      logic              zero_flag;
      logic              parity_flag;
   } outcome_type;

   outcome_type expected_outcomes[$];
   int          faults  = 0;
   int          pending = 0;
   int          reports = 0;

   assign fault_count = faults;
   assign outstanding = pending;

   // result of one request: scan forward / reverse, field extract, or all zero
   function automatic outcome_type bit_op_outcome(input logic [1:0]        cmd,
                                                  input logic [DATA_W-1:0] opnd,
                                                  input logic [DATA_W-1:0] second,
                                                  input logic [1:0]        size_sel);
      outcome_type       o;
      int unsigned       bits;
      int unsigned       start;
      int unsigned       len;
      int unsigned       span;
      logic [DATA_W-1:0] masked;
      logic [DATA_W-1:0] keep;
      o = '0;
      case (size_sel)
         SIZE_16: begin
            bits   = 16;
            masked = opnd & MASK_16;
         end
         SIZE_32: begin
            bits   = 32;
            masked = opnd & MASK_32;
         end
         default: begin
            bits   = 64;
            masked = opnd;
         end
      endcase
      case (cmd)
         CMD_BSF, CMD_BSR: begin
            if (masked == '0) begin
               o.result      = second;
               o.zero_flag   = 1'b1;
               o.parity_flag = 1'b1;
            end else begin
               // forward stops at the first set bit, reverse keeps the last one
               for (int i = 0; i < 64; i++) begin
                  if (masked[i]) begin
                     o.result = 64'(i);
                     if (cmd == CMD_BSF) break;
                  end
               end
               o.parity_flag = ~^o.result[7:0];
            end
         end
         CMD_BEXTR: begin
            start = second[7:0];
            len   = second[15:8];
            if (start >= bits || len == 0) begin
               o.zero_flag = 1'b1;
            end else begin
               span        = (len < bits - start) ? len : bits - start;
               keep        = (span == 64) ? MASK_64 : ((64'd1 << span) - 64'd1);
               o.result    = (opnd >> start) & keep;
               o.zero_flag = (o.result == '0);
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic log_fault(input string what);
      faults++;
      if (reports < 10) begin
         reports++;
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) begin
            expected_outcomes.push_back(bit_op_outcome(req_mon.cmd, req_mon.operand,
                                                       req_mon.second_operand,
                                                       req_mon.size_sel));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.result, rsp_mon.zero_flag, rsp_mon.parity_flag};
            if (expected_outcomes.size() == 0) begin
               log_fault($sformatf("result %h zf %b pf %b with no request pending",
                                   got.result, got.zero_flag, got.parity_flag));
            end else begin
               want = expected_outcomes.pop_front();
               if (got.result !== want.result || got.zero_flag !== want.zero_flag ||
                   got.parity_flag !== want.parity_flag) begin
                  log_fault($sformatf({"expected result %h zf %b pf %b, ",
                                       "got result %h zf %b pf %b"},
                                      want.result, want.zero_flag, want.parity_flag,
                                      got.result, got.zero_flag, got.parity_flag));
               end
            end
         end
      end
      pending = expected_outcomes.size();
   end

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
   import bsfe_pkg::*;

   // codes the package leaves unnamed: unused command and unused size selector
   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam logic [1:0] SIZE_UNUSED = 2'd3;

   localparam int RANDOM_REQUESTS = 1950;
   localparam int PHASE_REQUESTS  = RANDOM_REQUESTS / 3;
   // settling wait before the verdict, beyond the three-stage pipeline
   localparam int DRAIN_CYCLES    = 12;

   logic clock;
   logic reset;
   int   sender_idle_pct;
   int   receiver_idle_pct;
   int   fault_count;
   int   outstanding;

   bsfe_req_if req_ch ();
   bsfe_rsp_if rsp_ch ();

   bit_scan_and_field_extract_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // watches both channels, predicts each result and compares
   bsfe_outcome_checker outcome_chk (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .fault_count (fault_count),
      .outstanding (outstanding)
   );

   // 10 time unit clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // hard limit on the run, far beyond the slowest correct run
   initial begin
      #3_000_000;
      $display("bit_scan_and_field_extract_unit verification failed");
      $finish;
   end

   // result side: random back-pressure, changes only at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= (int'($urandom_range(99)) >= receiver_idle_pct);
      end
   end

   // one request: optional idle cycles, then hold valid until accepted
   // valid is left high on return so back-to-back requests keep it up
   task automatic send_request(input logic [1:0]  cmd,
                               input logic [63:0] opnd,
                               input logic [63:0] second,
                               input logic [1:0]  size_sel);
      @(negedge clock);
      while (int'($urandom_range(99)) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.cmd            <= cmd;
      req_ch.operand        <= opnd;
      req_ch.second_operand <= second;
      req_ch.size_sel       <= size_sel;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // stop sending until every pending result has come back
   task automatic wait_for_drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // operand shapes that reach the scan corners: zero, single bit, sparse,
   // zero low or high bits, and set bits only above the narrow sizes
   function automatic logic [63:0] pick_operand();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(7))
         0: v = '0;
         1: v = 64'd1 << $urandom_range(63);
         2: v = v & {$urandom, $urandom} & {$urandom, $urandom};
         3: v = v << $urandom_range(63);
         4: v = v >> $urandom_range(63);
         5: v = v & ~MASK_16;
         6: v = v & ~MASK_32;
         default: ;
      endcase
      return v;
   endfunction

   // extract control: mostly an in-range start and a length up to four past the size,
   // sometimes anything at all in the start and length bytes
   function automatic logic [63:0] pick_extract_ctrl(input logic [1:0] size_sel);
      logic [63:0] ctrl;
      logic [7:0]  start;
      logic [7:0]  len;
      int unsigned bits;
      ctrl  = {$urandom, $urandom};
      bits  = (size_sel == SIZE_16) ? 16 : (size_sel == SIZE_32) ? 32 : 64;
      start = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                       : 8'($urandom_range(bits - 1));
      len   = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                       : 8'($urandom_range(bits + 4));
      ctrl[15:0] = {len, start};
      return ctrl;
   endfunction

   task automatic send_random_request();
      logic [1:0]  cmd;
      logic [1:0]  size_sel;
      logic [63:0] opnd;
      logic [63:0] second;
      int unsigned pick;
      // the unused command and size show up now and then
      pick = $urandom_range(39);
      if (pick == 0) cmd = CMD_UNUSED;
      else if (pick <= 13) cmd = CMD_BSF;
      else if (pick <= 26) cmd = CMD_BSR;
      else cmd = CMD_BEXTR;
      pick = $urandom_range(19);
      if (pick == 0) size_sel = SIZE_UNUSED;
      else if (pick <= 6) size_sel = SIZE_16;
      else if (pick <= 12) size_sel = SIZE_32;
      else size_sel = SIZE_64;
      opnd   = pick_operand();
      second = (cmd == CMD_BEXTR) ? pick_extract_ctrl(size_sel) : {$urandom, $urandom};
      send_request(cmd, opnd, second, size_sel);
   endtask

   initial begin
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.cmd            = CMD_BSF;
      req_ch.operand        = '0;
      req_ch.second_operand = '0;
      req_ch.size_sel       = SIZE_16;
      sender_idle_pct       = 30;
      receiver_idle_pct     = 61;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // scan of zero passes the second operand through
      send_request(CMD_BSF, 64'h0, 64'hDEAD_BEEF_0123_4567, SIZE_64);
      // nonzero only above the size still counts as zero
      send_request(CMD_BSF, 64'hFFFF_FFFF_FFFF_0000, MASK_64, SIZE_16);
      send_request(CMD_BSR, 64'hFFFF_FFFF_0000_0000, 64'h0, SIZE_32);
      send_request(CMD_BSF, 64'h0, 64'h5A5A_A5A5_0F0F_F0F0, SIZE_UNUSED);
      // top and bottom bit indexes at 16 and 64 bits, the top one at 32
      send_request(CMD_BSF, 64'h8000_0000_0000_0000, 64'h0, SIZE_64);
      send_request(CMD_BSF, MASK_64, 64'h0, SIZE_64);
      send_request(CMD_BSR, MASK_64, 64'h0, SIZE_64);
      send_request(CMD_BSR, 64'h1, MASK_64, SIZE_16);
      send_request(CMD_BSR, MASK_64, 64'h0, SIZE_16);
      send_request(CMD_BSF, 64'h0000_0000_8000_0000, 64'h0, SIZE_32);
      send_request(CMD_BSR, 64'h0000_0000_0000_0180, 64'h0, SIZE_32);
      // unused size behaves as 64 bits
      send_request(CMD_BSR, 64'h0000_0001_0000_0000, 64'h0, SIZE_UNUSED);
      // extract: full width, length clipped, last bit
      send_request(CMD_BEXTR, 64'h0123_4567_89AB_CDEF, 64'h4000, SIZE_64);
      send_request(CMD_BEXTR, MASK_64, 64'hFF00, SIZE_32);
      send_request(CMD_BEXTR, 64'h8000_0000_0000_0000, 64'h013F, SIZE_64);
      send_request(CMD_BEXTR, 64'h0000_0000_0000_8000, 64'h080F, SIZE_16);
      send_request(CMD_BEXTR, MASK_64, 64'h2808, SIZE_32);
      send_request(CMD_BEXTR, MASK_64, 64'h1E28, SIZE_UNUSED);
      // extract: start out of range, zero length, zero field
      send_request(CMD_BEXTR, MASK_64, 64'h0840, SIZE_64);
      send_request(CMD_BEXTR, MASK_64, 64'h0410, SIZE_16);
      send_request(CMD_BEXTR, MASK_64, 64'hFFFF_FFFF_FFFF_0000, SIZE_64);
      send_request(CMD_BEXTR, MASK_64, 64'hFFFF, SIZE_64);
      send_request(CMD_BEXTR, 64'hFFFF_0000_FFFF_FFFF, 64'h1020, SIZE_64);
      // unused command gives an all-zero result
      send_request(CMD_UNUSED, MASK_64, MASK_64, SIZE_64);
      wait_for_drain();

      // three random phases: sender idles lightly, then receiver lightly, then none
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct   = 30;
               receiver_idle_pct = 61;
            end
            1: begin
               sender_idle_pct   = 61;
               receiver_idle_pct = 30;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            send_random_request();
            // one pause in the middle of the full-rate stream
            if (phase == 2 && n == PHASE_REQUESTS / 2) wait_for_drain();
         end
         wait_for_drain();
      end

      // let any stray result show up before the verdict
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fault_count == 0 && outstanding == 0) begin
         $display("bit_scan_and_field_extract_unit verification clean");
      end else begin
         $display("bit_scan_and_field_extract_unit verification failed");
      end
      $finish;
   end

endmodule
